>>> rtl/bsce_pkg.sv
package bsce_pkg;

  localparam int CODE_W = 64;
  localparam int LEN_W  = 6;

  // held button / symbol codes
  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_SELECT = 2'd1;
  localparam logic [1:0] BTN_DOWN   = 2'd2;
  localparam logic [1:0] BTN_UP     = 2'd3;

  // result outcomes
  localparam logic [1:0] OUT_SUBMIT  = 2'd0;
  localparam logic [1:0] OUT_EMPTY   = 2'd1;
  localparam logic [1:0] OUT_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_IDLE     = 2'd2;
  localparam logic [1:0] REG_THIRD    = 2'd3;

  localparam logic [9:0]  DEBOUNCE_RST = 10'd30;
  localparam logic [15:0] HOLD_RST     = 16'd1200;
  localparam logic [17:0] IDLE_RST     = 18'd120000;
  localparam logic        THIRD_RST    = 1'b1;

  localparam logic [15:0] PRESS_MAX = 16'hffff;
  localparam logic [17:0] IDLE_MAX  = 18'h3ffff;

  typedef struct packed {
    logic select_level;
    logic down_level;
    logic up_level;
  } tick_t;

  typedef struct packed {
    logic [1:0]        outcome;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } result_t;

  typedef struct packed {
    logic [9:0]  debounce_ticks;
    logic [15:0] hold_ticks;
    logic [17:0] idle_ticks;
    logic        third_button_enable;
  } cfg_t;

  // tick as classified by the front end
  typedef struct packed {
    tick_t      levels;
    logic [1:0] pick;
  } ctick_t;

endpackage

>>> rtl/bsce_fifo.sv
module bsce_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  // two-entry queue
  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> rtl/bsce_front.sv
module bsce_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bsce_pkg::tick_t   tick,
  output logic              full,
  input  logic              third_button_enable,
  input  logic              take,
  output bsce_pkg::ctick_t  item,
  output logic              valid
);

  bsce_pkg::ctick_t cls;
  logic             q_empty;

  // press priority: select, down, then up when enabled
  always_comb begin
    cls.levels = tick;
    if (tick.select_level) begin
      cls.pick = bsce_pkg::BTN_SELECT;
    end else if (tick.down_level) begin
      cls.pick = bsce_pkg::BTN_DOWN;
    end else if (tick.up_level && third_button_enable) begin
      cls.pick = bsce_pkg::BTN_UP;
    end else begin
      cls.pick = bsce_pkg::BTN_NONE;
    end
  end

  bsce_fifo #(.W($bits(bsce_pkg::ctick_t))) u_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (take),
    .rdata (item),
    .empty (q_empty)
  );

  assign valid = !q_empty;

endmodule

>>> rtl/bsce_back.sv
module bsce_back #(
  parameter int MAX_SYMBOLS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  bsce_pkg::cfg_t    cfg,
  input  logic              valid,
  input  bsce_pkg::ctick_t  item,
  output logic              take,
  input  logic              res_full,
  output logic              res_push,
  output bsce_pkg::result_t res
);

  localparam logic [1:0] PH_WAIT  = 2'd0;
  localparam logic [1:0] PH_PRESS = 2'd1;
  localparam logic [1:0] PH_DRAIN = 2'd2;

  logic [1:0]                    phase, phase_next;
  logic [15:0]                   press_timer, press_timer_next;
  logic [17:0]                   idle_timer, idle_timer_next;
  logic [1:0]                    held, held_next;
  logic [bsce_pkg::CODE_W-1:0]   store, store_next;
  logic [bsce_pkg::LEN_W-1:0]    total, total_next;
  logic [15:0]                   pt_inc;
  logic                          level;
  logic                          emit;

  assign take = valid && !res_full;

  always_comb begin
    phase_next       = phase;
    press_timer_next = press_timer;
    idle_timer_next  = idle_timer;
    held_next        = held;
    store_next       = store;
    total_next       = total;
    emit             = 1'b0;
    res.outcome      = bsce_pkg::OUT_SUBMIT;
    res.code_bits    = store;
    res.code_length  = total;
    pt_inc           = (press_timer < bsce_pkg::PRESS_MAX) ? press_timer + 16'd1 : press_timer;

    case (held)
      bsce_pkg::BTN_SELECT: level = item.levels.select_level;
      bsce_pkg::BTN_DOWN:   level = item.levels.down_level;
      default:              level = item.levels.up_level;
    endcase

    if (take) begin
      case (phase)
        PH_PRESS: begin
          press_timer_next = pt_inc;
          if (pt_inc >= {6'd0, cfg.debounce_ticks}) begin
            if (!level) begin
              // released: append, dropping beyond capacity
              if (total < bsce_pkg::LEN_W'(MAX_SYMBOLS)) begin
                for (int i = 0; i < MAX_SYMBOLS; i++) begin
                  if (total == bsce_pkg::LEN_W'(i)) begin
                    store_next[2*i +: 2] = held;
                  end
                end
                total_next = total + 6'd1;
              end
              idle_timer_next  = '0;
              phase_next       = PH_WAIT;
              held_next        = bsce_pkg::BTN_NONE;
              press_timer_next = '0;
            end else if (held == bsce_pkg::BTN_SELECT && pt_inc >= cfg.hold_ticks) begin
              phase_next = PH_DRAIN;
            end
          end
        end
        PH_DRAIN: begin
          if (!item.levels.select_level) begin
            emit = 1'b1;
            if (total == '0) begin
              res.outcome = bsce_pkg::OUT_EMPTY;
            end
          end
        end
        default: begin
          phase_next = PH_WAIT;
          if (idle_timer >= cfg.idle_ticks) begin
            emit            = 1'b1;
            res.outcome     = bsce_pkg::OUT_TIMEOUT;
            res.code_bits   = '0;
            res.code_length = '0;
          end else begin
            if (idle_timer < bsce_pkg::IDLE_MAX) begin
              idle_timer_next = idle_timer + 18'd1;
            end
            if (item.pick != bsce_pkg::BTN_NONE) begin
              held_next        = item.pick;
              phase_next       = PH_PRESS;
              press_timer_next = '0;
            end
          end
        end
      endcase

      if (emit) begin
        store_next       = '0;
        total_next       = '0;
        idle_timer_next  = '0;
        phase_next       = PH_WAIT;
        press_timer_next = '0;
        held_next        = bsce_pkg::BTN_NONE;
      end
    end
  end

  assign res_push = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      press_timer <= '0;
      idle_timer  <= '0;
      held        <= bsce_pkg::BTN_NONE;
      store       <= '0;
      total       <= '0;
    end else begin
      phase       <= phase_next;
      press_timer <= press_timer_next;
      idle_timer  <= idle_timer_next;
      held        <= held_next;
      store       <= store_next;
      total       <= total_next;
    end
  end

endmodule

>>> rtl/button_sequence_code_entry.sv
// Button code entry. Each request on the tick channel is one millisecond tick
// with three button levels (select, down, up).
// Tick channel: a request is taken when push is high and full is low.
// Result channel: the oldest result shows on result while empty is low and
// is taken when pop is high and empty is low. At most one result per tick:
// submitted sequence, empty submit or idle timeout.
// Config: cfg_we writes cfg_data into register cfg_index (0 debounce,
// 1 hold, 2 idle limit, 3 third button enable) in the same edge; write only
// while no ticks are in flight.
// Path: a tick's request is registered in the tick queue; the back end
// retires it from there and writes its result into the result queue,
// from which the result can be popped.
// Throughput: one tick per cycle while the result queue is not full; the
// front end classifies and queues ticks, the back end state machine retires
// one tick per cycle, set by its single timer/store update path.
// Stall: while the result queue (two entries) is full the back end holds;
// the tick queue (two entries) keeps taking requests until it fills too.
// Reset (rst, synchronous): queues empty, state waiting, timers and symbol
// store clear, registers at 30 / 1200 / 120000 / 1.
module button_sequence_code_entry #(
  parameter int MAX_SYMBOLS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bsce_pkg::tick_t   tick,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output bsce_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [17:0]       cfg_data
);

  bsce_pkg::cfg_t    cfg;
  bsce_pkg::ctick_t  item;
  bsce_pkg::result_t res;
  logic              item_valid;
  logic              take;
  logic              res_full;
  logic              res_push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks      <= bsce_pkg::DEBOUNCE_RST;
      cfg.hold_ticks          <= bsce_pkg::HOLD_RST;
      cfg.idle_ticks          <= bsce_pkg::IDLE_RST;
      cfg.third_button_enable <= bsce_pkg::THIRD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bsce_pkg::REG_DEBOUNCE: cfg.debounce_ticks      <= cfg_data[9:0];
        bsce_pkg::REG_HOLD:     cfg.hold_ticks          <= cfg_data[15:0];
        bsce_pkg::REG_IDLE:     cfg.idle_ticks          <= cfg_data;
        bsce_pkg::REG_THIRD:    cfg.third_button_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front end: press priority and tick queue
  bsce_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .tick                (tick),
    .full                (full),
    .third_button_enable (cfg.third_button_enable),
    .take                (take),
    .item                (item),
    .valid               (item_valid)
  );

  // back end: phase machine, timers, symbol store
  bsce_back #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .valid    (item_valid),
    .item     (item),
    .take     (take),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  // result queue
  bsce_fifo #(.W($bits(bsce_pkg::result_t))) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

`ifndef SYNTHESIS
  // a timeout never carries symbols
  a_timeout_clear: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.outcome == bsce_pkg::OUT_TIMEOUT) |->
      (result.code_length == '0 && result.code_bits == '0))
    else $error("timeout result carries symbols");

  // a submitted sequence holds at least one symbol, within capacity
  a_submit_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.outcome == bsce_pkg::OUT_SUBMIT) |->
      (result.code_length != '0 && result.code_length <= 6'(MAX_SYMBOLS)))
    else $error("submitted length out of range");

  // an empty submit carries nothing
  a_empty_clear: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.outcome == bsce_pkg::OUT_EMPTY) |->
      (result.code_length == '0 && result.code_bits == '0))
    else $error("empty submit carries symbols");

  // the back end only produces a result while it retires a tick
  a_push_take: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (take && !res_full))
    else $error("result produced without a tick");
`endif

endmodule
